[hdl/sorted_index_run_coalescer_assert.svh]
// ----------------------------------------------------------------------------
// sorted index run coalescer assertion macros
// Concurrent assertion shorthands clocked on i_clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_INDEX_RUN_COALESCER_ASSERT_SVH
`define SORTED_INDEX_RUN_COALESCER_ASSERT_SVH

// same-cycle implication
`define SIRC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SIRC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/sirc_pkg.sv]
// ----------------------------------------------------------------------------
// sirc_pkg
// Shared constants and types of the sorted index run coalescer.
// ----------------------------------------------------------------------------
package sirc_pkg;

    // capacity of the sorting chain, 2 to 64 cells
    localparam int MAX_INDICES = 32;
    localparam int IDX_W       = 32;
    localparam int CNT_W       = 6;
    // longest run reported as one range
    localparam logic [CNT_W-1:0] RUN_LIMIT = 6'd32;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    // command broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             shift;
        logic [IDX_W-1:0] val;
    } t_cell_ctl;

    // run emitter status toward the top level
    typedef struct packed {
        logic busy;
        logic pop;
        logic done;
    } t_emit_ctl;

endpackage

[hdl/sirc_cell.sv]
// ----------------------------------------------------------------------------
// sirc_cell
// One slot of the sorted chain: takes part in a sorted insert or shifts
// toward the head during range emission.
// ----------------------------------------------------------------------------
module sirc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sirc_pkg::t_cell_ctl        i_ctl,
    input  logic                       i_left_valid,
    input  logic                       i_left_gt,
    input  logic [sirc_pkg::IDX_W-1:0] i_left_val,
    input  logic                       i_right_valid,
    input  logic [sirc_pkg::IDX_W-1:0] i_right_val,
    output logic                       o_valid,
    output logic                       o_gt,
    output logic [sirc_pkg::IDX_W-1:0] o_val
);
    import sirc_pkg::*;

    logic             r_valid;
    logic             n_valid;
    logic [IDX_W-1:0] r_val;
    logic [IDX_W-1:0] n_val;

    // this entry sits above the incoming index
    assign o_gt    = r_valid && (r_val > i_ctl.val);
    assign o_valid = r_valid;
    assign o_val   = r_val;

    // shift: take the right neighbour's entry; insert: shift the larger tail up, the boundary cell takes the new index
    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        if (i_ctl.shift) begin
            n_valid = i_right_valid;
            n_val   = i_right_val;
        end else if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_valid = 1'b1;
                n_val   = i_left_val;
            end else if (o_gt || (!r_valid && i_left_valid)) begin
                n_valid = 1'b1;
                n_val   = i_ctl.val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

[hdl/sirc_run_emit.sv]
// ----------------------------------------------------------------------------
// sirc_run_emit
// Pops the chain head once per cycle after the last index and merges
// consecutive values into start and count ranges.
// ----------------------------------------------------------------------------
module sirc_run_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic                       i_head_valid,
    input  logic [sirc_pkg::IDX_W-1:0] i_head_val,
    input  logic                       i_overflow,
    output sirc_pkg::t_emit_ctl        o_ctl,
    output logic                       o_valid,
    output logic [sirc_pkg::IDX_W-1:0] o_range_start,
    output logic [sirc_pkg::CNT_W-1:0] o_range_count,
    output logic                       o_last_range,
    output logic                       o_overflow
);
    import sirc_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic             r_have;
    logic             n_have;
    logic [IDX_W-1:0] r_start;
    logic [IDX_W-1:0] n_start;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [IDX_W-1:0] r_prev;
    logic [IDX_W-1:0] n_prev;
    logic             r_valid;
    logic             n_valid;
    logic             n_last;
    logic             r_last;
    logic [IDX_W-1:0] r_out_start;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_ovf;
    logic             w_extend;

    // head continues the open run
    assign w_extend = r_have && (i_head_val == r_prev + IDX_W'(1))
                      && (i_head_val != '0) && (r_cnt < RUN_LIMIT);

    // next state and run bookkeeping
    always_comb begin
        n_state = r_state;
        n_have  = r_have;
        n_start = r_start;
        n_cnt   = r_cnt;
        n_prev  = r_prev;
        n_valid = 1'b0;
        n_last  = 1'b0;
        o_ctl   = '0;
        case (r_state)
            ST_COLLECT: begin
                if (i_go) begin
                    n_state = ST_EMIT;
                    n_have  = 1'b0;
                end
            end
            ST_EMIT: begin
                o_ctl.busy = 1'b1;
                if (i_head_valid) begin
                    o_ctl.pop = 1'b1;
                    n_prev    = i_head_val;
                    if (w_extend) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_valid = r_have;
                        n_start = i_head_val;
                        n_cnt   = 6'd1;
                        n_have  = 1'b1;
                    end
                end else begin
                    o_ctl.done = 1'b1;
                    n_valid    = 1'b1;
                    n_last     = 1'b1;
                    n_have     = 1'b0;
                    n_state    = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_have  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
            r_valid <= n_valid;
        end
    end

    // run and result payload
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_cnt   <= n_cnt;
        r_prev  <= n_prev;
        if (n_valid) begin
            r_out_start <= r_start;
            r_out_cnt   <= r_cnt;
            r_last      <= n_last;
            r_out_ovf   <= i_overflow;
        end
    end

    assign o_valid       = r_valid;
    assign o_range_start = r_out_start;
    assign o_range_count = r_out_cnt;
    assign o_last_range  = r_last;
    assign o_overflow    = r_out_ovf;

endmodule

[hdl/sorted_index_run_coalescer.sv]
// ----------------------------------------------------------------------------
// sorted_index_run_coalescer
// Sorts a set of 32-bit indices in a cell chain and reports the runs of
// consecutive values as start and count ranges.
// ----------------------------------------------------------------------------
// Usage:
//   An index transaction is taken on a rising edge with start high and busy
//   low; i_last_index marks the final index of a set. Each taken index is
//   inserted into the sorted chain in that same cycle, so indices may follow
//   back to back at one per cycle while the set is collected.
//   Indices beyond MAX_INDICES are dropped and o_overflow is raised on every
//   range of that set.
//   After the last index, busy rises and the emitter pops one chain entry
//   per cycle through the single pop port at the chain head. Each range
//   appears on o_range_start and o_range_count for one cycle with o_valid
//   high, the final one with o_last_range; results leave in the cycle after
//   the pop that closes them, and busy is low again when the final range is
//   shown.
//   The receiver cannot stall: every strobed range is taken.
//   Reset (i_rst_n low, synchronous) empties the chain and clears overflow.
// ----------------------------------------------------------------------------
module sorted_index_run_coalescer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sirc_pkg::IDX_W-1:0] i_index_value,
    input  logic                       i_last_index,
    output logic                       o_valid,
    output logic [sirc_pkg::IDX_W-1:0] o_range_start,
    output logic [sirc_pkg::CNT_W-1:0] o_range_count,
    output logic                       o_last_range,
    output logic                       o_overflow
);
    import sirc_pkg::*;

`include "sorted_index_run_coalescer_assert.svh"

    logic [MAX_INDICES-1:0] w_valid;
    logic [MAX_INDICES-1:0] w_gt;
    logic [IDX_W-1:0]       w_val [MAX_INDICES];
    logic                   w_accept;
    logic                   w_full;
    t_cell_ctl              w_cell_ctl;
    t_emit_ctl              w_emit_ctl;
    logic                   r_overflow;
    logic                   n_overflow;

    // transaction acceptance
    assign busy     = w_emit_ctl.busy;
    assign w_accept = start && !busy;
    assign w_full   = w_valid[MAX_INDICES-1];

    assign w_cell_ctl.ins   = w_accept && !w_full;
    assign w_cell_ctl.shift = w_emit_ctl.pop;
    assign w_cell_ctl.val   = i_index_value;

    // sorted cell chain
    for (genvar g = 0; g < MAX_INDICES; g++) begin : g_cell
        if (g == 0) begin : g_head
            sirc_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_cell_ctl),
                .i_left_valid  (1'b1),
                .i_left_gt     (1'b0),
                .i_left_val    ('0),
                .i_right_valid (w_valid[g+1]),
                .i_right_val   (w_val[g+1]),
                .o_valid       (w_valid[g]),
                .o_gt          (w_gt[g]),
                .o_val         (w_val[g])
            );
        end else if (g == MAX_INDICES - 1) begin : g_tail
            sirc_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_cell_ctl),
                .i_left_valid  (w_valid[g-1]),
                .i_left_gt     (w_gt[g-1]),
                .i_left_val    (w_val[g-1]),
                .i_right_valid (1'b0),
                .i_right_val   ('0),
                .o_valid       (w_valid[g]),
                .o_gt          (w_gt[g]),
                .o_val         (w_val[g])
            );
        end else begin : g_mid
            sirc_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_cell_ctl),
                .i_left_valid  (w_valid[g-1]),
                .i_left_gt     (w_gt[g-1]),
                .i_left_val    (w_val[g-1]),
                .i_right_valid (w_valid[g+1]),
                .i_right_val   (w_val[g+1]),
                .o_valid       (w_valid[g]),
                .o_gt          (w_gt[g]),
                .o_val         (w_val[g])
            );
        end
    end

    // dropped index flag for the current set
    always_comb begin
        n_overflow = r_overflow;
        if (w_emit_ctl.done) begin
            n_overflow = 1'b0;
        end else if (w_accept && w_full) begin
            n_overflow = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overflow <= 1'b0;
        end else begin
            r_overflow <= n_overflow;
        end
    end

    // range emission from the chain head
    sirc_run_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (w_accept && i_last_index),
        .i_head_valid  (w_valid[0]),
        .i_head_val    (w_val[0]),
        .i_overflow    (r_overflow),
        .o_ctl         (w_emit_ctl),
        .o_valid       (o_valid),
        .o_range_start (o_range_start),
        .o_range_count (o_range_count),
        .o_last_range  (o_last_range),
        .o_overflow    (o_overflow)
    );

    // checks
    `SIRC_ASSERT_NOW(a_count_range, o_valid,
        (o_range_count != '0) && (o_range_count <= RUN_LIMIT),
        "range count out of bounds")
    `SIRC_ASSERT_NEXT(a_last_starts_emit, w_accept && i_last_index, busy,
        "emission did not start after last index")
    `SIRC_ASSERT_NOW(a_final_frees, o_valid && o_last_range, !busy,
        "still busy after final range")
    `SIRC_ASSERT_NOW(a_chain_packed, 1'b1,
        (w_valid & (w_valid + MAX_INDICES'(1))) == '0,
        "cell chain occupancy not packed at the head")

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Sends sets of 32-bit indices into the run coalescer, one transaction at a
// time. A behavioral sort and run split predicts the ranges of every set, and
// each strobed range is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import sirc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * MAX_INDICES + 8;

    typedef struct packed {
        logic [IDX_W-1:0] value;
        logic             last;
        logic             hold_for_drain;
    } t_index_txn;

    typedef struct packed {
        logic [IDX_W-1:0] start_idx;
        logic [CNT_W-1:0] count;
        logic             last;
        logic             overflow;
    } t_range;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             start         = 1'b0;
    logic [IDX_W-1:0] i_index_value = '0;
    logic             i_last_index  = 1'b0;
    logic             busy;
    logic             o_valid;
    logic [IDX_W-1:0] o_range_start;
    logic [CNT_W-1:0] o_range_count;
    logic             o_last_range;
    logic             o_overflow;

    // stimulus and expectations
    t_index_txn index_backlog[$];
    t_range     expected_ranges[$];

    // predictor state
    logic [IDX_W-1:0] sorted_model [0:MAX_INDICES-1];
    int               model_fill     = 0;
    bit               model_dropped  = 1'b0;

    int ranges_predicted = 0;
    int ranges_seen      = 0;
    int items_taken      = 0;
    int sets_done        = 0;
    int sets_overflowed  = 0;
    int error_count      = 0;
    int stall_cycles     = 0;

    sorted_index_run_coalescer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_index_value (i_index_value),
        .i_last_index  (i_last_index),
        .o_valid       (o_valid),
        .o_range_start (o_range_start),
        .o_range_count (o_range_count),
        .o_last_range  (o_last_range),
        .o_overflow    (o_overflow)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // insert one index in sorted order; on the last one split the set into runs
    task automatic insert_and_coalesce(input logic [IDX_W-1:0] value, input logic last);
        int               pos;
        int               run_len;
        logic [IDX_W-1:0] run_first;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] prev;
        t_range           rng;
        if (model_fill < MAX_INDICES) begin
            pos = model_fill;
            while (pos > 0 && sorted_model[pos-1] > value) begin
                sorted_model[pos] = sorted_model[pos-1];
                pos--;
            end
            sorted_model[pos] = value;
            model_fill++;
        end else begin
            model_dropped = 1'b1;
        end
        if (!last) return;

        run_first = sorted_model[0];
        run_len   = 1;
        for (int k = 1; k <= model_fill; k++) begin
            if (k < model_fill) begin
                cur  = sorted_model[k];
                prev = sorted_model[k-1];
            end
            // a duplicate or a gap closes the run, so does a full run
            if (k < model_fill && cur == prev + 32'd1 && cur != '0 && run_len < RUN_LIMIT) begin
                run_len++;
            end else begin
                rng.start_idx = run_first;
                rng.count     = run_len[CNT_W-1:0];
                rng.last      = (k == model_fill);
                rng.overflow  = model_dropped;
                expected_ranges.insert(expected_ranges.size(), rng);
                ranges_predicted++;
                run_first = cur;
                run_len   = 1;
            end
        end
        sets_done++;
        if (model_dropped) sets_overflowed++;
        model_fill    = 0;
        model_dropped = 1'b0;
    endtask

    task automatic push_index(input logic [IDX_W-1:0] value, input logic last,
                              input logic hold = 1'b0);
        t_index_txn txn;
        txn.value          = value;
        txn.last           = last;
        txn.hold_for_drain = hold;
        index_backlog.insert(index_backlog.size(), txn);
    endtask

    // style 0 scattered, 1 clustered with duplicates, 2 shuffled consecutive
    task automatic queue_set(input int n, input int style, input logic hold);
        logic [IDX_W-1:0] vals [0:63];
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] tmp;
        int               j;
        if ($urandom_range(0, 3) == 0) base = 32'hFFFF_FFFF - $urandom_range(0, 48);
        else base = $urandom;
        for (int k = 0; k < n; k++) begin
            case (style)
                0: vals[k] = $urandom;
                1: vals[k] = base + $urandom_range(0, n + n / 4);
                default: vals[k] = base + k;
            endcase
        end
        if (style == 2 && n > 1 && $urandom_range(0, 3) == 0)
            vals[$urandom_range(0, n - 1)] = vals[$urandom_range(0, n - 1)];
        for (int k = n - 1; k > 0; k--) begin
            j       = $urandom_range(0, k);
            tmp     = vals[k];
            vals[k] = vals[j];
            vals[j] = tmp;
        end
        for (int k = 0; k < n; k++)
            push_index(vals[k], k == n - 1, hold && k == 0);
    endtask

    // driver: one transaction held until taken, then the next from the backlog
    always @(posedge i_clk) begin
        t_index_txn next_txn;
        bit         idle_now;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                insert_and_coalesce(i_index_value, i_last_index);
                items_taken++;
            end
            if (!start || !busy) begin
                idle_now = !(items_taken >= 80 && items_taken < 130)
                           && $urandom_range(0, 99) < 34;
                if (index_backlog.size() != 0 && !idle_now
                    && !(index_backlog[0].hold_for_drain && ranges_predicted != ranges_seen)) begin
                    next_txn      = index_backlog.pop_front();
                    start         <= 1'b1;
                    i_index_value <= next_txn.value;
                    i_last_index  <= next_txn.last;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed range is compared with the oldest prediction
    always @(posedge i_clk) begin
        t_range want;
        if (i_rst_n && o_valid) begin
            if (expected_ranges.size() == 0) begin
                $error("unexpected range: start %h count %0d last %b overflow %b",
                       o_range_start, o_range_count, o_last_range, o_overflow);
                error_count++;
            end else begin
                want = expected_ranges.pop_front();
                if (o_range_start !== want.start_idx) begin
                    $error("range_start: expected %h, got %h", want.start_idx, o_range_start);
                    error_count++;
                end
                if (o_range_count !== want.count) begin
                    $error("range_count: expected %0d, got %0d", want.count, o_range_count);
                    error_count++;
                end
                if (o_last_range !== want.last) begin
                    $error("last_range: expected %b, got %b", want.last, o_last_range);
                    error_count++;
                end
                if (o_overflow !== want.overflow) begin
                    $error("overflow: expected %b, got %b", want.overflow, o_overflow);
                    error_count++;
                end
                ranges_seen <= ranges_seen + 1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin
        int random_items;
        int roll;
        int n;

        // extremes of the index range, single-index sets
        push_index(32'hFFFF_FFFF, 1'b1);
        push_index(32'h0000_0000, 1'b1);
        // one run given out of order
        push_index(32'd3, 1'b0);
        push_index(32'd1, 1'b0);
        push_index(32'd2, 1'b0);
        push_index(32'd0, 1'b1);
        // duplicates split a run, gap before the last value
        push_index(32'd7, 1'b0);
        push_index(32'd5, 1'b0);
        push_index(32'd5, 1'b0);
        push_index(32'd6, 1'b0);
        push_index(32'd9, 1'b1);
        // sign-bit boundary and top of range, sent only after a full drain
        push_index(32'h8000_0000, 1'b0, 1'b1);
        push_index(32'h7FFF_FFFF, 1'b0);
        push_index(32'hFFFF_FFFE, 1'b0);
        push_index(32'hFFFF_FFFF, 1'b0);
        push_index(32'h0000_0001, 1'b1);
        // alternating bit patterns
        push_index(32'hAAAA_AAAA, 1'b0);
        push_index(32'h5555_5555, 1'b1);

        // full-length run with the last index dropped, then a clustered overflow
        queue_set(MAX_INDICES + 1, 2, 1'b1);
        queue_set(MAX_INDICES + 8, 1, 1'b0);

        random_items = 0;
        while (random_items < 85) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) n = $urandom_range(1, 8);
            else if (roll < 90) n = $urandom_range(9, 24);
            else n = $urandom_range(30, 40);
            queue_set(n, $urandom_range(0, 2), $urandom_range(0, 5) == 0);
            random_items += n;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (index_backlog.size() != 0 || start) @(posedge i_clk);
        while (ranges_predicted != ranges_seen) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_ranges.size() != 0) begin
            $error("%0d predicted ranges never arrived", expected_ranges.size());
            error_count++;
        end
        $display("run covered %0d index transactions in %0d sets, %0d with dropped indices",
                 items_taken, sets_done, sets_overflowed);
        $display("%0d ranges compared, %0d mismatches", ranges_seen, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
